[src/http_chunked_body_decoder_defines.svh]
// Assertion macros shared by the chunked body decoder modules.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/hcbd_pkg.sv]
// Types, constants and helper functions for the chunked body decoder.
`timescale 1ns / 1ps
package hcbd_pkg;

  localparam int SizeBitsDef = 32;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharSp = 8'h20;
  localparam logic [7:0] CharTab = 8'h09;

  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_DIGITS   = 4'd1,
    PH_REST     = 4'd2,
    PH_DATA     = 4'd3,
    PH_DATA_CR  = 4'd4,
    PH_DATA_LF  = 4'd5,
    PH_TRAILER  = 4'd6,
    PH_DONE_OK  = 4'd7,
    PH_DONE_ERR = 4'd8
  } hcbd_phase_e;

  typedef enum logic [1:0] {
    STATUS_BUSY = 2'd0,
    STATUS_OK   = 2'd1,
    STATUS_ERR  = 2'd2
  } hcbd_status_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       final_byte;
  } hcbd_req_t;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         data_valid;
    hcbd_status_e status;
    logic         last;
  } hcbd_rsp_t;

  // Control part of the parser state; the size counter travels separately.
  typedef struct packed {
    hcbd_phase_e phase;
    logic        prev_cr;
    logic [1:0]  trailer_bytes;
  } hcbd_ctl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hcbd_hex_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CharSp) || ((b >= CharTab) && (b <= CharCr));
  endfunction

  function automatic hcbd_hex_t hex_digit(input logic [7:0] b);
    hcbd_hex_t h;
    h = '0;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage

[src/hcbd_step.sv]
// Next-state and result logic for one body byte.
`timescale 1ns / 1ps
module hcbd_step import hcbd_pkg::*; #(
  parameter int SIZE_BITS = SizeBitsDef
) (
  input  hcbd_req_t              req_i,
  input  hcbd_ctl_t              ctl_q_i,
  input  logic [SIZE_BITS-1:0]   size_q_i,
  output hcbd_ctl_t              ctl_d_o,
  output logic [SIZE_BITS-1:0]   size_d_o,
  output hcbd_rsp_t              rsp_o
);

  hcbd_hex_t  hex;
  logic [7:0] b;
  logic       fail;
  logic       done;
  logic       halted;

  assign b   = req_i.body_byte;
  assign hex = hex_digit(b);

  always_comb begin
    ctl_d_o  = ctl_q_i;
    size_d_o = size_q_i;
    rsp_o    = '0;
    fail     = 1'b0;
    done     = 1'b0;
    halted   = 1'b0;
    unique case (ctl_q_i.phase)
      PH_LEAD, PH_DIGITS, PH_REST: begin
        if (ctl_q_i.prev_cr && (b == CharLf)) begin
          ctl_d_o.prev_cr = 1'b0;
          if (ctl_q_i.phase == PH_LEAD) begin
            fail = 1'b1;
          end else if (size_q_i == '0) begin
            ctl_d_o.phase         = PH_TRAILER;
            ctl_d_o.trailer_bytes = 2'd0;
          end else begin
            ctl_d_o.phase = PH_DATA;
          end
        end else begin
          if (ctl_q_i.phase == PH_LEAD) begin
            if (!is_space(b)) begin
              if (!hex.ok) begin
                fail = 1'b1;
              end else begin
                size_d_o      = SIZE_BITS'(hex.val);
                ctl_d_o.phase = PH_DIGITS;
              end
            end
          end else if (ctl_q_i.phase == PH_DIGITS) begin
            if (!hex.ok) begin
              ctl_d_o.phase = PH_REST;
            end else if (|size_q_i[SIZE_BITS-1 -: 4]) begin
              // another digit would overflow the size field
              fail = 1'b1;
            end else begin
              size_d_o = {size_q_i[SIZE_BITS-5:0], hex.val};
            end
          end
          ctl_d_o.prev_cr = (b == CharCr);
        end
      end
      PH_DATA: begin
        rsp_o.data_byte  = b;
        rsp_o.data_valid = 1'b1;
        size_d_o         = size_q_i - SIZE_BITS'(1);
        if (size_q_i == SIZE_BITS'(1)) begin
          ctl_d_o.phase = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (b == CharCr) begin
          ctl_d_o.phase = PH_DATA_LF;
        end else begin
          fail = 1'b1;
        end
      end
      PH_DATA_LF: begin
        if (b == CharLf) begin
          ctl_d_o.phase   = PH_LEAD;
          ctl_d_o.prev_cr = 1'b0;
          size_d_o        = '0;
        end else begin
          fail = 1'b1;
        end
      end
      PH_TRAILER: begin
        if (ctl_q_i.prev_cr && (b == CharLf)) begin
          ctl_d_o.prev_cr = 1'b0;
          // a line holding only CR ends the message
          done                  = (ctl_q_i.trailer_bytes == 2'd1);
          ctl_d_o.trailer_bytes = 2'd0;
        end else begin
          if (ctl_q_i.trailer_bytes != 2'd3) begin
            ctl_d_o.trailer_bytes = ctl_q_i.trailer_bytes + 2'd1;
          end
          ctl_d_o.prev_cr = (b == CharCr);
        end
      end
      PH_DONE_OK: begin
        halted       = 1'b1;
        rsp_o.status = STATUS_OK;
      end
      default: begin
        halted       = 1'b1;
        rsp_o.status = STATUS_ERR;
      end
    endcase

    if (!halted) begin
      if (done) begin
        ctl_d_o.phase = PH_DONE_OK;
        rsp_o.status  = STATUS_OK;
        rsp_o.last    = 1'b1;
      end else if (fail || req_i.final_byte) begin
        ctl_d_o.phase = PH_DONE_ERR;
        rsp_o.status  = STATUS_ERR;
        rsp_o.last    = 1'b1;
      end
    end
  end

endmodule

[src/hcbd_outbuf.sv]
// Result register with a skid stage between parser and receiver.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_defines.svh"
module hcbd_outbuf import hcbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  hcbd_rsp_t push_rsp_i,
  output logic      push_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output hcbd_rsp_t out_rsp_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  hcbd_rsp_t out_rsp_q, out_rsp_d;
  hcbd_rsp_t skid_rsp_q, skid_rsp_d;
  logic      push;
  logic      pop;

  assign push_stall_o = skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign pop          = out_valid_q && !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign out_rsp_o    = out_rsp_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_rsp_d    = out_rsp_q;
    skid_valid_d = skid_valid_q;
    skid_rsp_d   = skid_rsp_q;
    if (!out_valid_q || pop) begin
      // drain the skid first to keep order
      out_valid_d  = skid_valid_q || push;
      out_rsp_d    = skid_valid_q ? skid_rsp_q : push_rsp_i;
      skid_valid_d = 1'b0;
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_rsp_d   = push_rsp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q  <= out_rsp_d;
    skid_rsp_q <= skid_rsp_d;
  end

  `HCBD_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds data with output empty")
  `HCBD_ASSERT_NEXT(a_stalled_push_skids, out_valid_q && out_stall_i && push, skid_valid_q, "stalled request was not parked")
  `HCBD_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall_i, !skid_valid_q, "skid not drained on pop")

endmodule

[src/http_chunked_body_decoder.sv]
// Top level of the chunked transfer body decoder.
// Usage:
//   Input channel in_valid_i / in_stall_o / in_req_i carries one body byte per
//   request with a final_byte flag on the last byte available. Output channel
//   out_valid_o / out_stall_i / out_rsp_o returns exactly one result per input
//   byte: the payload byte with data_valid when it belongs to a chunk, the
//   status (in progress, complete, malformed) and last on the ending byte.
//   An accepted byte's result is registered in the output register, or in the
//   skid stage while a stall holds it. Throughput is one byte per cycle while
//   the receiver does not stall: the parser state updates in the accepting
//   cycle through a single digit shift or size decrement.
//   When the receiver stalls, the output register holds and a one-entry skid
//   stage takes one more result; in_stall_o rises while the skid is full.
//   Reset clears the parser to the start of a size line, the size counter to
//   zero and both result stages to empty. After completion or failure the
//   block keeps answering each byte with the final status and last low until
//   the next reset.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_defines.svh"
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int SIZE_BITS = SizeBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hcbd_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output hcbd_rsp_t out_rsp_o
);

  hcbd_ctl_t            ctl_q, ctl_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  hcbd_rsp_t            step_rsp;
  logic                 accept;

  assign accept = in_valid_i && !in_stall_o;

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .req_i   (in_req_i),
    .ctl_q_i (ctl_q),
    .size_q_i(size_q),
    .ctl_d_o (ctl_d),
    .size_d_o(size_d),
    .rsp_o   (step_rsp)
  );

  hcbd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i),
    .push_rsp_i  (step_rsp),
    .push_stall_o(in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.phase         <= PH_LEAD;
      ctl_q.prev_cr       <= 1'b0;
      ctl_q.trailer_bytes <= 2'd0;
      size_q              <= '0;
    end else if (accept) begin
      ctl_q  <= ctl_d;
      size_q <= size_d;
    end
  end

  `HCBD_ASSERT_NOW(a_data_nonzero, ctl_q.phase == PH_DATA, size_q != '0, "data phase with zero remaining")
  `HCBD_ASSERT_NOW(a_payload_in_data, step_rsp.data_valid, ctl_q.phase == PH_DATA, "payload flagged outside chunk data")
  `HCBD_ASSERT_NEXT(a_end_sticks, accept && step_rsp.last, ctl_q.phase == PH_DONE_OK || ctl_q.phase == PH_DONE_ERR, "message end did not stick")

endmodule
